### rtl/sbpd_pkg.sv
// Shared constants for the start-byte packet deframer.
package sbpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 10;   // three payload bytes sum to at most 765

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd253;
  localparam logic [BYTE_W:0]   CSUM_MOD       = 9'd255;

endpackage : sbpd_pkg

### rtl/sbpd_csum_check.sv
// Mod-255 checksum check of a packet's payload sum against the received byte.
module sbpd_csum_check (
  input  logic [sbpd_pkg::SUM_W-1:0]  sum,
  input  logic [sbpd_pkg::BYTE_W-1:0] csum_byte,
  output logic                        mismatch
);

  logic [sbpd_pkg::BYTE_W:0] fold;
  logic [sbpd_pkg::BYTE_W:0] rem;
  logic [sbpd_pkg::BYTE_W:0] expected;

  // 256 == 1 mod 255: fold the high bits onto the low byte, then one subtract
  assign fold = {1'b0, sum[sbpd_pkg::BYTE_W-1:0]}
              + {{(2*sbpd_pkg::BYTE_W-sbpd_pkg::SUM_W+1){1'b0}},
                 sum[sbpd_pkg::SUM_W-1:sbpd_pkg::BYTE_W]};
  assign rem      = (fold >= sbpd_pkg::CSUM_MOD) ? fold - sbpd_pkg::CSUM_MOD : fold;
  // remainder 0 gives an expected checksum of 255
  assign expected = sbpd_pkg::CSUM_MOD - rem;
  assign mismatch = (expected != {1'b0, csum_byte});

endmodule : sbpd_csum_check

### rtl/start_byte_packet_deframer.sv
// Start-byte packet deframer: hunts for a start byte, collects 3 payload bytes + checksum.
// out_valid rises once the checksum byte has passed the input register and then the
//   result register; the packet transfers on an edge with out_stall low.
// Throughput: one byte per cycle; the input stalls only while a finished result
//   is held in the result register by out_stall and the next byte is a checksum.
// Reset (rst_n, synchronous, active low): back to hunting, running sum and both
//   valid flags cleared, start byte register set to 253.
module start_byte_packet_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [sbpd_pkg::BYTE_W-1:0] cfg_wr_data,
  // received bytes
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbpd_pkg::BYTE_W-1:0] in_rx_byte,
  // decoded packets
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbpd_pkg::BYTE_W-1:0] out_channel_id,
  output logic [sbpd_pkg::BYTE_W-1:0] out_value_first,
  output logic [sbpd_pkg::BYTE_W-1:0] out_value_second,
  output logic                        out_status
);

  // Packet phase; codes 5..7 are unused and behave as hunting.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_PAY1 = 3'd1,
    PH_PAY2 = 3'd2,
    PH_PAY3 = 3'd3,
    PH_CHK  = 3'd4
  } phase_t;

  // start byte register
  logic [sbpd_pkg::BYTE_W-1:0] start_byte_r, start_byte_nxt;

  // input register stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] s1_byte_r,  s1_byte_nxt;

  // deframer state
  phase_t                      phase_r, phase_nxt;
  logic [sbpd_pkg::SUM_W-1:0]  sum_r,   sum_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] pay0_r, pay0_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] pay1_r, pay1_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] pay2_r, pay2_nxt;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] out_chan_r,  out_chan_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] out_v1_r,    out_v1_nxt;
  logic [sbpd_pkg::BYTE_W-1:0] out_v2_r,    out_v2_nxt;
  logic                        out_stat_r,  out_stat_nxt;

  logic in_xfer;
  logic out_free;
  logic s1_go;
  logic csum_bad;

  // Result register can load when it is empty or its result leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Only a checksum byte needs room in the result register.
  assign s1_go    = s1_valid_r && ((phase_r != PH_CHK) || out_free);
  // Input register is free when empty or when its byte is consumed now.
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  sbpd_csum_check u_csum (
    .sum       (sum_r),
    .csum_byte (s1_byte_r),
    .mismatch  (csum_bad)
  );

  always_comb begin
    start_byte_nxt = cfg_wr_en ? cfg_wr_data : start_byte_r;

    s1_valid_nxt = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    s1_byte_nxt  = in_xfer ? in_rx_byte : s1_byte_r;

    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    pay0_nxt  = pay0_r;
    pay1_nxt  = pay1_r;
    pay2_nxt  = pay2_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_chan_nxt  = out_chan_r;
    out_v1_nxt    = out_v1_r;
    out_v2_nxt    = out_v2_r;
    out_stat_nxt  = out_stat_r;

    if (s1_go) begin
      unique case (phase_r)
        PH_PAY1: begin
          pay0_nxt  = s1_byte_r;
          sum_nxt   = sum_r + {{(sbpd_pkg::SUM_W-sbpd_pkg::BYTE_W){1'b0}}, s1_byte_r};
          phase_nxt = PH_PAY2;
        end
        PH_PAY2: begin
          pay1_nxt  = s1_byte_r;
          sum_nxt   = sum_r + {{(sbpd_pkg::SUM_W-sbpd_pkg::BYTE_W){1'b0}}, s1_byte_r};
          phase_nxt = PH_PAY3;
        end
        PH_PAY3: begin
          pay2_nxt  = s1_byte_r;
          sum_nxt   = sum_r + {{(sbpd_pkg::SUM_W-sbpd_pkg::BYTE_W){1'b0}}, s1_byte_r};
          phase_nxt = PH_CHK;
        end
        PH_CHK: begin
          // checksum byte: emit the packet, good or bad, and go back to hunting
          out_valid_nxt = 1'b1;
          out_chan_nxt  = pay0_r;
          out_v1_nxt    = pay1_r;
          out_v2_nxt    = pay2_r;
          out_stat_nxt  = csum_bad;
          phase_nxt     = PH_HUNT;
          sum_nxt       = '0;
        end
        default: begin
          // hunting (and unused codes): drop everything but the start byte
          if (s1_byte_r == start_byte_r) begin
            phase_nxt = PH_PAY1;
            sum_nxt   = '0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= sbpd_pkg::START_BYTE_RST;
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_HUNT;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      start_byte_r <= start_byte_nxt;
      s1_valid_r   <= s1_valid_nxt;
      phase_r      <= phase_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    // payload registers, no reset
    s1_byte_r  <= s1_byte_nxt;
    pay0_r     <= pay0_nxt;
    pay1_r     <= pay1_nxt;
    pay2_r     <= pay2_nxt;
    out_chan_r <= out_chan_nxt;
    out_v1_r   <= out_v1_nxt;
    out_v2_r   <= out_v2_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_channel_id   = out_chan_r;
  assign out_value_first  = out_v1_r;
  assign out_value_second = out_v2_r;
  assign out_status       = out_stat_r;

endmodule : start_byte_packet_deframer

### rtl/sbpd_checker.sv
// Port-level checks for the start-byte packet deframer, bound to the top level.
module sbpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sbpd_pkg::BYTE_W-1:0] out_channel_id,
  input logic [sbpd_pkg::BYTE_W-1:0] out_value_first,
  input logic [sbpd_pkg::BYTE_W-1:0] out_value_second,
  input logic                        out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel_id)
      && $stable(out_value_first) && $stable(out_value_second) && $stable(out_status))
    else $error("stalled result changed");

  // input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // result register is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a new result follows an earlier input transfer, through the input register and then the result register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding input transfer");

endmodule : sbpd_checker

bind start_byte_packet_deframer sbpd_checker u_sbpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_channel_id   (out_channel_id),
  .out_value_first  (out_value_first),
  .out_value_second (out_value_second),
  .out_status       (out_status)
);

### verif/sbpd_checker.sv
// Checker for the start-byte packet deframer: tracks framing, predicts packets, compares outputs.
module sbpd_tb_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [sbpd_pkg::BYTE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [sbpd_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sbpd_pkg::BYTE_W-1:0] out_channel_id,
  input  logic [sbpd_pkg::BYTE_W-1:0] out_value_first,
  input  logic [sbpd_pkg::BYTE_W-1:0] out_value_second,
  input  logic                        out_status,
  output int                          fail_count,
  output int                          pending,
  output int                          packets_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [sbpd_pkg::BYTE_W-1:0] byte_t;
  typedef enum logic [2:0] {HUNT, TAKE_CHAN, TAKE_FIRST, TAKE_SECOND, TAKE_CSUM} frame_phase_t;

  localparam int CSUM_W = sbpd_pkg::BYTE_W + 1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    byte_t chan;
    byte_t first;
    byte_t second;
    logic  status;
  } packet_t;

  packet_t                    expected_packets[$];
  frame_phase_t               phase;
  byte_t                      start_sel;
  byte_t                      held[3];
  logic [sbpd_pkg::SUM_W-1:0] payload_sum;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Advance the framing state by one accepted byte; queue a packet on the checksum byte.
  task automatic track_byte(byte_t b);
    logic [CSUM_W-1:0] want_csum;
    packet_t           pkt;
    unique case (phase)
      TAKE_CHAN, TAKE_FIRST, TAKE_SECOND: begin
        held[2'(int'(phase) - 1)] = b;
        payload_sum = payload_sum
                    + {{(sbpd_pkg::SUM_W-sbpd_pkg::BYTE_W){1'b0}}, b};
        phase = frame_phase_t'(phase + 3'd1);
      end
      TAKE_CSUM: begin
        // sum a multiple of 255 wants 255, never 0
        want_csum  = CSUM_W'(sbpd_pkg::CSUM_MOD - (payload_sum % sbpd_pkg::CSUM_MOD));
        pkt.chan   = held[0];
        pkt.first  = held[1];
        pkt.second = held[2];
        pkt.status = (want_csum == {1'b0, b}) ? STATUS_GOOD : STATUS_BAD;
        expected_packets.insert(expected_packets.size(), pkt);
        phase       = HUNT;
        payload_sum = '0;
      end
      default: begin
        if (b == start_sel) begin
          phase       = TAKE_CHAN;
          payload_sum = '0;
        end else begin
          phase = HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    packet_t want;
    if (!rst_n) begin
      phase       = HUNT;
      payload_sum = '0;
      start_sel   = sbpd_pkg::START_BYTE_RST;
      expected_packets.delete();
    end else begin
      // compare first so a packet queued at this edge is never matched early
      if (out_valid && !out_stall) begin
        if (expected_packets.size() == 0) begin
          $error("packet with no expectation: chan %0d first %0d second %0d status %0d",
                 out_channel_id, out_value_first, out_value_second, out_status);
          fail_count++;
        end else begin
          want = expected_packets.pop_front();
          check_field("channel_id", want.chan, out_channel_id);
          check_field("value_first", want.first, out_value_first);
          check_field("value_second", want.second, out_value_second);
          check_field("status", want.status, out_status);
          packets_done++;
        end
      end
      if (in_valid && !in_stall) track_byte(in_rx_byte);
      if (cfg_wr_en) start_sel = cfg_wr_data;
    end
    pending = expected_packets.size();
  end

endmodule : sbpd_tb_checker

### verif/tb_start_byte_packet_deframer.sv
// Testbench top for the start-byte packet deframer: stimulus, flow control and verdict.
module tb_start_byte_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [sbpd_pkg::BYTE_W-1:0] byte_t;

  localparam int CLK_HALF     = 4;     // 8 ns period
  localparam int RESET_CYCLES = 7;
  localparam int MAX_WAIT     = 18;    // longest idle either side draws per transfer
  localparam int LONG_HOLD    = 240;   // receiver back-pressure stretch, in cycles
  localparam int SETTLE       = 6;     // > input-plus-result register pipeline, lets partial frames land
  localparam int PHASE_BYTES  = 300;   // framed bytes per start-byte setting

  logic  clk         = 1'b0;
  logic  rst_n       = 1'b0;
  logic  cfg_wr_en   = 1'b0;
  byte_t cfg_wr_data = '0;
  logic  in_valid    = 1'b0;
  logic  in_stall;
  byte_t in_rx_byte  = '0;
  logic  out_valid;
  logic  out_stall   = 1'b0;
  byte_t out_channel_id;
  byte_t out_value_first;
  byte_t out_value_second;
  logic  out_status;

  int fail_count;
  int pending;
  int packets_done;

  // Stimulus-side copy of the start byte, only used to build frames.
  byte_t start_sel      = sbpd_pkg::START_BYTE_RST;
  bit    send_quiet     = 1'b0;   // sender runs back to back while set
  bit    recv_quiet     = 1'b0;   // receiver draws no random stall while set
  bit    long_hold_req  = 1'b0;   // asks the receiver for one long stall
  int    bytes_sent     = 0;
  int    framed_bytes   = 0;
  int    settings_used  = 1;      // reset value counts as the first setting

  always #CLK_HALF clk = ~clk;

  start_byte_packet_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel_id   (out_channel_id),
    .out_value_first  (out_value_first),
    .out_value_second (out_value_second),
    .out_status       (out_status)
  );

  sbpd_tb_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel_id   (out_channel_id),
    .out_value_first  (out_value_first),
    .out_value_second (out_value_second),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .packets_done     (packets_done)
  );

  // Idle draw per transfer; quiet stretches give runs with no gaps at all.
  function automatic int pick_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Payload bytes lean on the extremes now and then.
  function automatic byte_t pick_byte();
    unique case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Checksum that a well-formed frame carries: 255 - (sum mod 255).
  function automatic byte_t good_csum(byte_t a, byte_t b, byte_t c);
    int s;
    s = a + b + c;
    return byte_t'(255 - (s % 255));
  endfunction

  // One transfer on the input channel. Entered and left at a falling edge;
  // valid stays high into the next byte when that byte draws no gap.
  task automatic send_byte(byte_t b);
    int gap;
    gap = pick_wait(send_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Full frame: start byte, three payload bytes, checksum (optionally wrong).
  task automatic send_packet(byte_t chan, byte_t first, byte_t second, bit corrupt);
    byte_t csum;
    csum = good_csum(chan, first, second);
    // any nonzero xor guarantees a mismatch
    if (corrupt) csum = csum ^ byte_t'($urandom_range(1, 255));
    send_byte(start_sel);
    send_byte(chan);
    send_byte(first);
    send_byte(second);
    send_byte(csum);
    framed_bytes += 5;
  endtask

  // Sender pause: nothing offered until every expected packet is out, then a
  // SETTLE wait so a half-finished frame in the input stage settles.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_start_byte(byte_t v);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    start_sel   = v;
    settings_used++;
  endtask

  // Random traffic: mostly well-formed frames with random content, plus
  // line noise and truncated frames that knock the framing off alignment.
  task automatic random_phase(int n_framed);
    int target;
    int r;
    target = framed_bytes + n_framed;
    while (framed_bytes < target) begin
      if ($urandom_range(0, 9) == 0) send_quiet = ~send_quiet;
      r = $urandom_range(0, 9);
      if (r <= 7) begin
        send_packet(pick_byte(), pick_byte(), pick_byte(), $urandom_range(0, 3) == 0);
      end else if (r == 8) begin
        repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        // start byte then a short frame: the next frame's bytes finish it
        send_byte(start_sel);
        repeat ($urandom_range(1, 3)) send_byte(pick_byte());
        framed_bytes += 2;
      end
    end
    send_quiet = 1'b0;
  endtask

  // Receiver: random stall before each packet transfer, quiet stretches, and
  // one long hold counted here while the sender keeps offering bytes.
  initial begin : receiver
    int gap;
    bit long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      gap = pick_wait(recv_quiet);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      if ($urandom_range(0, 11) == 0) recv_quiet = ~recv_quiet;
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    byte_t random_start;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset start byte.
    // Noise while hunting is dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Plain good frame.
    send_packet(8'h01, 8'h80, 8'h7F, 1'b0);
    // All-ones payload: sum is a multiple of 255, checksum 255 is good.
    send_packet(8'hFF, 8'hFF, 8'hFF, 1'b0);
    // All-zero payload with checksum 0: sum a multiple of 255, so mismatch.
    send_byte(start_sel);
    repeat (4) send_byte(8'h00);
    framed_bytes += 5;
    // Start byte inside a frame is just data.
    send_packet(start_sel, start_sel, start_sel, 1'b0);
    // Bad checksum still yields a packet, flagged.
    send_packet(8'h12, 8'h34, 8'h56, 1'b1);

    // Random part at the reset setting.
    random_phase(PHASE_BYTES);

    // Extremes of the register; the long receiver hold lands in this phase.
    write_start_byte(8'h00);
    long_hold_req = 1'b1;
    random_phase(PHASE_BYTES);

    write_start_byte(8'hFF);
    random_phase(PHASE_BYTES / 2);
    // mid-phase sender pause until the output side is empty
    drain();
    random_phase(PHASE_BYTES / 2);

    random_start = byte_t'($urandom_range(1, 254));
    write_start_byte(random_start);
    random_phase(PHASE_BYTES);

    // Back to the reset value through a write.
    write_start_byte(sbpd_pkg::START_BYTE_RST);
    random_phase(PHASE_BYTES);

    // End of stimulus: wait for the last packets, then let the pipeline settle.
    drain();

    $display("covered %0d received bytes (%0d framed) and %0d decoded packets",
             bytes_sent, framed_bytes, packets_done);
    $display("over %0d start-byte settings, with noise, truncated frames and back-pressure",
             settings_used);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d packets still expected", pending);
    $display("status: fail");
    $finish;
  end

endmodule : tb_start_byte_packet_deframer
